/* design/cbn_pkg.sv */
package cbn_pkg;

   localparam int MAX_KEPT_DEF = 64;
   localparam int NUM_CLASSES  = 256;
   localparam int IOU_LAT      = 5;
   localparam int CSR_INDEX_W  = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CONF_THRESHOLD = 2'd0,
      CSR_IOU_THRESHOLD  = 2'd1,
      CSR_IMAGE_HEIGHT   = 2'd2,
      CSR_IMAGE_WIDTH    = 2'd3
   } csr_index_type;

   // One kept box: corners in Q4.13, class and precomputed area.
   typedef struct packed {
      logic signed [17:0] x1;
      logic signed [17:0] y1;
      logic signed [17:0] x2;
      logic signed [17:0] y2;
      logic [7:0]         cls;
      logic [31:0]        area;
   } entry_type;

endpackage

/* design/class_aware_box_nms_unit.sv */
// Class-aware greedy box suppression. Each request beat carries one detection
// (center, size, objectness, class probability, class, frame end mark), given in
// descending score order, and yields exactly one response beat in the same order.
// Kept boxes live in a ring of MAX_KEPT cells that rotates once per detection,
// presenting every stored box to a single five-stage overlap unit. A detection
// passes from its request beat through a setup step, the rotation of the ring,
// the drain of the overlap unit and a commit step, and the block takes no new
// request beat until it has gone back to its idle state, in which the
// next request beat is taken. A response beat that is still waiting holds the
// commit cycle, and with it the request channel, until it is taken. The store
// starts empty after reset and is emptied after the last detection of each
// frame. Configuration writes are taken at any time through the csr channel,
// but they should only be made while no detection is in flight.
module class_aware_box_nms_unit #(
   parameter int MAX_KEPT = cbn_pkg::MAX_KEPT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [15:0]                  req_center_x,
   input  logic signed [15:0]                  req_center_y,
   input  logic [14:0]                         req_box_width,
   input  logic [14:0]                         req_box_height,
   input  logic [15:0]                         req_objectness,
   input  logic [15:0]                         req_class_prob,
   input  logic [7:0]                          req_class_id,
   input  logic                                req_frame_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_kept,
   output logic [14:0]                         rsp_pix_top,
   output logic [14:0]                         rsp_pix_left,
   output logic signed [15:0]                  rsp_pix_bottom,
   output logic signed [15:0]                  rsp_pix_right,
   output logic [15:0]                         rsp_kept_score,
   output logic [7:0]                          rsp_kept_class,
   output logic                                rsp_frame_done,
   output logic                                rsp_store_full,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cbn_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [15:0]                         csr_data
);

   localparam int CNT_W   = $clog2(MAX_KEPT + 1);
   localparam int DRAIN_W = $clog2(cbn_pkg::IOU_LAT + 1);
   localparam logic signed [18:0] PIX_LOW_MAX = 19'sd32767;
   localparam logic signed [18:0] PIX_NEG_LIM = -19'sd32768;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_SCAN,
      ST_DRAIN,
      ST_FINISH
   } state_type;

   // Truncate a scaled corner toward zero, dropping the Q.13 fraction.
   function automatic logic signed [18:0] to_pixel(input logic signed [31:0] p);
      logic [31:0] mag;
      logic [18:0] sh;
      mag = p[31] ? (~p + 32'd1) : p;
      sh  = mag[31:13];
      return $signed(p[31] ? (~sh + 19'd1) : sh);
   endfunction

   function automatic logic [14:0] clamp_low(input logic signed [18:0] r);
      logic [14:0] v;
      if (r < 19'sd0) begin
         v = 15'd0;
      end else if (r > PIX_LOW_MAX) begin
         v = 15'h7FFF;
      end else begin
         v = r[14:0];
      end
      return v;
   endfunction

   function automatic logic [15:0] clamp_high(input logic signed [18:0] r,
                                              input logic [12:0] cap);
      logic [15:0] v;
      if (r > $signed({6'b0, cap})) begin
         v = {3'b0, cap};
      end else if (r < PIX_NEG_LIM) begin
         v = 16'h8000;
      end else begin
         v = r[15:0];
      end
      return v;
   endfunction

   state_type          state_ff;
   logic [15:0]        conf_thr_ff, iou_thr_ff;
   logic [12:0]        img_h_ff, img_w_ff;
   logic [CNT_W-1:0]   count_ff, step_ff;
   logic [DRAIN_W-1:0] drain_ff;
   logic               sticky_ff;
   cbn_pkg::entry_type query_ff;
   logic [14:0]        bw_ff, bh_ff;
   logic [15:0]        obj_ff, cp_ff, score_ff;
   logic               last_ff;
   logic signed [31:0] prod_top_ff, prod_left_ff, prod_bottom_ff, prod_right_ff;

   logic               rsp_valid_ff, rsp_kept_ff, rsp_frame_done_ff, rsp_store_full_ff;
   logic [14:0]        rsp_pix_top_ff, rsp_pix_left_ff;
   logic [15:0]        rsp_pix_bottom_ff, rsp_pix_right_ff;
   logic [15:0]        rsp_kept_score_ff;
   logic [7:0]         rsp_kept_class_ff;

   cbn_pkg::entry_type ring [MAX_KEPT];
   logic               shift_en, issue_valid, iou_hit;
   logic               out_free, base_keep, keep_final, has_room, store_we, commit;
   logic signed [13:0] scale_h, scale_w;
   logic [31:0]        score_prod;
   logic [29:0]        area_prod;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      scale_h     = $signed({1'b0, img_h_ff});
      scale_w     = $signed({1'b0, img_w_ff});
      score_prod  = obj_ff * cp_ff;
      area_prod   = bw_ff * bh_ff;
      shift_en    = (state_ff == ST_SCAN);
      // Only entries below the fill count are live; the head cell holds entry step_ff.
      issue_valid = shift_en && (step_ff < count_ff) && (ring[0].cls == query_ff.cls);
      out_free    = !rsp_valid_ff || rsp_ready;
      base_keep   = (score_ff >= conf_thr_ff) &&
                    ({1'b0, query_ff.cls} < 9'(cbn_pkg::NUM_CLASSES));
      keep_final  = base_keep && !sticky_ff;
      has_room    = (count_ff < CNT_W'(MAX_KEPT));
      commit      = (state_ff == ST_FINISH) && out_free;
      // The ring is back in its home alignment here, so entry k sits in cell k.
      store_we    = commit && keep_final && has_room;
   end

   for (genvar i = 0; i < MAX_KEPT; i++) begin : g_cell
      localparam int NEXT = (i + 1) % MAX_KEPT;
      cbn_cell u_cell (
         .clock      (clock),
         .shift_en   (shift_en),
         .load_en    (store_we && (count_ff == CNT_W'(i))),
         .load_entry (query_ff),
         .next_entry (ring[NEXT]),
         .entry      (ring[i])
      );
   end

   cbn_iou u_iou (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (issue_valid),
      .query         (query_ff),
      .stored        (ring[0]),
      .iou_threshold (iou_thr_ff),
      .hit           (iou_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         conf_thr_ff  <= 16'd32768;
         iou_thr_ff   <= 16'd29491;
         img_h_ff     <= 13'd416;
         img_w_ff     <= 13'd416;
         count_ff     <= '0;
         step_ff      <= '0;
         drain_ff     <= '0;
         sticky_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            unique case (cbn_pkg::csr_index_type'(csr_index))
               cbn_pkg::CSR_CONF_THRESHOLD: conf_thr_ff <= csr_data;
               cbn_pkg::CSR_IOU_THRESHOLD:  iou_thr_ff  <= csr_data;
               cbn_pkg::CSR_IMAGE_HEIGHT:   img_h_ff    <= csr_data[12:0];
               cbn_pkg::CSR_IMAGE_WIDTH:    img_w_ff    <= csr_data[12:0];
               default: ;
            endcase
         end
         // A commit in the same cycle loads the next beat instead.
         if (rsp_valid_ff && rsp_ready && !commit) begin
            rsp_valid_ff <= 1'b0;
         end
         if (iou_hit) begin
            sticky_ff <= 1'b1;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  query_ff.x1  <= $signed({req_center_x[15], req_center_x, 1'b0}) -
                                  $signed({3'b0, req_box_width});
                  query_ff.y1  <= $signed({req_center_y[15], req_center_y, 1'b0}) -
                                  $signed({3'b0, req_box_height});
                  query_ff.x2  <= $signed({req_center_x[15], req_center_x, 1'b0}) +
                                  $signed({3'b0, req_box_width});
                  query_ff.y2  <= $signed({req_center_y[15], req_center_y, 1'b0}) +
                                  $signed({3'b0, req_box_height});
                  query_ff.cls <= req_class_id;
                  bw_ff        <= req_box_width;
                  bh_ff        <= req_box_height;
                  obj_ff       <= req_objectness;
                  cp_ff        <= req_class_prob;
                  last_ff      <= req_frame_last;
                  sticky_ff    <= 1'b0;
                  state_ff     <= ST_PREP;
               end
            end
            ST_PREP: begin
               score_ff       <= score_prod[31:16];
               query_ff.area  <= {area_prod, 2'b00};
               prod_top_ff    <= $signed(query_ff.y1) * scale_h;
               prod_left_ff   <= $signed(query_ff.x1) * scale_w;
               prod_bottom_ff <= $signed(query_ff.y2) * scale_h;
               prod_right_ff  <= $signed(query_ff.x2) * scale_w;
               step_ff        <= '0;
               state_ff       <= ST_SCAN;
            end
            ST_SCAN: begin
               step_ff <= step_ff + CNT_W'(1);
               if (step_ff == CNT_W'(MAX_KEPT - 1)) begin
                  drain_ff <= '0;
                  state_ff <= ST_DRAIN;
               end
            end
            ST_DRAIN: begin
               drain_ff <= drain_ff + DRAIN_W'(1);
               if (drain_ff == DRAIN_W'(cbn_pkg::IOU_LAT - 1)) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (out_free) begin
                  rsp_valid_ff      <= 1'b1;
                  rsp_kept_ff       <= keep_final;
                  rsp_store_full_ff <= keep_final && !has_room;
                  rsp_pix_top_ff    <= clamp_low(to_pixel(prod_top_ff));
                  rsp_pix_left_ff   <= clamp_low(to_pixel(prod_left_ff));
                  rsp_pix_bottom_ff <= clamp_high(to_pixel(prod_bottom_ff), img_h_ff);
                  rsp_pix_right_ff  <= clamp_high(to_pixel(prod_right_ff), img_w_ff);
                  rsp_kept_score_ff <= score_ff;
                  rsp_kept_class_ff <= query_ff.cls;
                  rsp_frame_done_ff <= last_ff;
                  if (last_ff) begin
                     count_ff <= '0;
                  end else if (store_we) begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kept       = rsp_kept_ff;
   assign rsp_pix_top    = rsp_pix_top_ff;
   assign rsp_pix_left   = rsp_pix_left_ff;
   assign rsp_pix_bottom = rsp_pix_bottom_ff;
   assign rsp_pix_right  = rsp_pix_right_ff;
   assign rsp_kept_score = rsp_kept_score_ff;
   assign rsp_kept_class = rsp_kept_class_ff;
   assign rsp_frame_done = rsp_frame_done_ff;
   assign rsp_store_full = rsp_store_full_ff;

   // The fill count never passes the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_KEPT))
      else $error("kept count exceeds store size");

   // A full-store flag only ever accompanies a kept detection.
   a_full_kept: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_store_full |-> rsp_kept)
      else $error("store full flagged on a dropped detection");

   // Committing the last detection of a frame empties the store.
   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      commit && last_ff |=> count_ff == '0)
      else $error("store not emptied at frame end");

   // Overlap hits only come back while a detection is being checked.
   a_hit_window: assert property (@(posedge clock) disable iff (reset)
      iou_hit |-> state_ff == ST_SCAN || state_ff == ST_DRAIN)
      else $error("overlap hit outside the check window");

endmodule

/* design/cbn_cell.sv */
module cbn_cell (
   input  logic               clock,
   input  logic               shift_en,
   input  logic               load_en,
   input  cbn_pkg::entry_type load_entry,
   input  cbn_pkg::entry_type next_entry,
   output cbn_pkg::entry_type entry
);

   cbn_pkg::entry_type entry_ff;

   always_ff @(posedge clock) begin
      if (load_en) begin
         entry_ff <= load_entry;
      end else if (shift_en) begin
         entry_ff <= next_entry;
      end
   end

   assign entry = entry_ff;

endmodule

/* design/cbn_iou.sv */
module cbn_iou (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  cbn_pkg::entry_type query,
   input  cbn_pkg::entry_type stored,
   input  logic [15:0]        iou_threshold,
   output logic               hit
);

   logic signed [17:0] xi1, yi1, xi2, yi2;
   logic signed [18:0] ow, oh;
   logic               overlap;
   logic [48:0]        prod, lhs;

   logic        v1_ff, v2_ff, v3_ff, v4_ff, hit_ff;
   logic [15:0] ow_ff, oh_ff;
   logic [32:0] sum1_ff, sum2_ff, uni_ff;
   logic [31:0] inter2_ff, inter3_ff, inter4_ff;
   logic [32:0] plo_ff;
   logic [31:0] phi_ff;

   always_comb begin
      xi1 = ($signed(query.x1) > $signed(stored.x1)) ? query.x1 : stored.x1;
      yi1 = ($signed(query.y1) > $signed(stored.y1)) ? query.y1 : stored.y1;
      xi2 = ($signed(query.x2) < $signed(stored.x2)) ? query.x2 : stored.x2;
      yi2 = ($signed(query.y2) < $signed(stored.y2)) ? query.y2 : stored.y2;
      ow = $signed({xi2[17], xi2}) - $signed({xi1[17], xi1});
      oh = $signed({yi2[17], yi2}) - $signed({yi1[17], yi1});
      overlap = (ow > 19'sd0) && (oh > 19'sd0);
      prod = {phi_ff, 17'b0} + {16'b0, plo_ff};
      lhs  = {1'b0, inter4_ff, 16'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         v1_ff  <= in_valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= v3_ff;
         hit_ff <= v4_ff && (lhs > prod);
      end
      // An overlap width is bounded by the narrower box, so 16 bits hold it.
      ow_ff     <= overlap ? ow[15:0] : 16'd0;
      oh_ff     <= overlap ? oh[15:0] : 16'd0;
      sum1_ff   <= {1'b0, query.area} + {1'b0, stored.area};
      inter2_ff <= ow_ff * oh_ff;
      sum2_ff   <= sum1_ff;
      uni_ff    <= sum2_ff - {1'b0, inter2_ff};
      inter3_ff <= inter2_ff;
      // Threshold times union split in two partial products.
      plo_ff    <= iou_threshold * uni_ff[16:0];
      phi_ff    <= iou_threshold * uni_ff[32:17];
      inter4_ff <= inter3_ff;
   end

   assign hit = hit_ff;

endmodule

/* tb/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   // One detection as it goes onto the request channel.
   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic [14:0]        bw;
      logic [14:0]        bh;
      logic [15:0]        obj;
      logic [15:0]        cp;
      logic [7:0]         cls;
      logic               last;
   } detection_type;

   // One verdict as it comes back on the response channel.
   typedef struct packed {
      logic               kept;
      logic [14:0]        top;
      logic [14:0]        left;
      logic signed [15:0] bottom;
      logic signed [15:0] right;
      logic [15:0]        score;
      logic [7:0]         cls;
      logic               frame_done;
      logic               store_full;
   } verdict_type;

   // The scoreboard keeps its own copy of the registers and of the kept-box
   // store, predicts the verdict of every accepted detection and compares
   // each response beat against the oldest pending verdict.
   class nms_scoreboard;
      longint       conf_thr, iou_thr, img_h, img_w;
      longint       kx1[cbn_pkg::MAX_KEPT_DEF], ky1[cbn_pkg::MAX_KEPT_DEF];
      longint       kx2[cbn_pkg::MAX_KEPT_DEF], ky2[cbn_pkg::MAX_KEPT_DEF];
      int           kcls[cbn_pkg::MAX_KEPT_DEF];
      int           kept_boxes;
      verdict_type  pending_verdicts[$];
      int           mismatches;

      function new();
         conf_thr   = 32768;
         iou_thr    = 29491;
         img_h      = 416;
         img_w      = 416;
         kept_boxes = 0;
         mismatches = 0;
      endfunction

      function void write_reg(cbn_pkg::csr_index_type idx, logic [15:0] data);
         case (idx)
            cbn_pkg::CSR_CONF_THRESHOLD: conf_thr = data;
            cbn_pkg::CSR_IOU_THRESHOLD:  iou_thr  = data;
            cbn_pkg::CSR_IMAGE_HEIGHT:   img_h    = data[12:0];
            cbn_pkg::CSR_IMAGE_WIDTH:    img_w    = data[12:0];
            default: ;
         endcase
      endfunction

      // Corner in Q4.13 times the image size, truncated toward zero.
      function longint to_pixel(longint corner, longint scale);
         longint p;
         p = corner * scale;
         if (p < 0) return -((-p) >>> 13);
         return p >>> 13;
      endfunction

      function bit overlaps_too_much(int k, longint x1, longint y1, longint x2,
                                     longint y2);
         longint ix1, iy1, ix2, iy2;
         longint unsigned inter, uni;
         ix1 = (kx1[k] > x1) ? kx1[k] : x1;
         iy1 = (ky1[k] > y1) ? ky1[k] : y1;
         ix2 = (kx2[k] < x2) ? kx2[k] : x2;
         iy2 = (ky2[k] < y2) ? ky2[k] : y2;
         inter = 0;
         if (ix2 > ix1 && iy2 > iy1) inter = (ix2 - ix1) * (iy2 - iy1);
         uni = (kx2[k] - kx1[k]) * (ky2[k] - ky1[k]) + (x2 - x1) * (y2 - y1) - inter;
         return (inter << 16) > longint'(iou_thr) * uni;
      endfunction

      function void log_detection(detection_type d);
         longint      x1, y1, x2, y2, score, top, left, bottom, right;
         bit          keep, full;
         verdict_type v;
         x1 = 2 * longint'(d.cx) - longint'(d.bw);
         y1 = 2 * longint'(d.cy) - longint'(d.bh);
         x2 = 2 * longint'(d.cx) + longint'(d.bw);
         y2 = 2 * longint'(d.cy) + longint'(d.bh);
         score = (longint'(d.obj) * longint'(d.cp)) >> 16;
         keep = (score >= conf_thr) && (int'(d.cls) < cbn_pkg::NUM_CLASSES);
         full = 0;
         for (int k = 0; k < kept_boxes && keep; k++)
            if (kcls[k] == int'(d.cls) && overlaps_too_much(k, x1, y1, x2, y2)) keep = 0;
         if (keep) begin
            if (kept_boxes < cbn_pkg::MAX_KEPT_DEF) begin
               kx1[kept_boxes]  = x1;
               ky1[kept_boxes]  = y1;
               kx2[kept_boxes]  = x2;
               ky2[kept_boxes]  = y2;
               kcls[kept_boxes] = d.cls;
               kept_boxes++;
            end else begin
               full = 1;
            end
         end
         top    = to_pixel(y1, img_h);
         left   = to_pixel(x1, img_w);
         bottom = to_pixel(y2, img_h);
         right  = to_pixel(x2, img_w);
         if (top < 0) top = 0;
         if (top > 32767) top = 32767;
         if (left < 0) left = 0;
         if (left > 32767) left = 32767;
         if (bottom > img_h) bottom = img_h;
         if (bottom < -32768) bottom = -32768;
         if (right > img_w) right = img_w;
         if (right < -32768) right = -32768;
         v.kept       = keep;
         v.top        = top[14:0];
         v.left       = left[14:0];
         v.bottom     = bottom[15:0];
         v.right      = right[15:0];
         v.score      = score[15:0];
         v.cls        = d.cls;
         v.frame_done = d.last;
         v.store_full = full;
         pending_verdicts.push_back(v);
         if (d.last) kept_boxes = 0;
      endfunction

      function void check_result(verdict_type got);
         verdict_type want;
         if (pending_verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Response beat with no detection pending: %p", got);
            return;
         end
         want = pending_verdicts.pop_front();
         if (want.kept !== got.kept || want.top !== got.top || want.left !== got.left ||
             want.bottom !== got.bottom || want.right !== got.right ||
             want.score !== got.score || want.cls !== got.cls ||
             want.frame_done !== got.frame_done || want.store_full !== got.store_full) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("Verdict mismatch at %0t", $realtime);
               $display("   expected %p", want);
               $display("   actual   %p", got);
            end
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   detection_type      req_det = '0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   verdict_type        rsp_got;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [cbn_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0]        csr_data = '0;

   nms_scoreboard      sb = new();
   bit                 idling_on = 1;   // random gaps on both sides
   bit                 long_hold = 0;   // asks the receiver for one long hold-off
   int                 idle_cycles = 0;
   int                 detections_sent = 0;

   always #5 clock = ~clock;

   class_aware_box_nms_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_center_x   (req_det.cx),
      .req_center_y   (req_det.cy),
      .req_box_width  (req_det.bw),
      .req_box_height (req_det.bh),
      .req_objectness (req_det.obj),
      .req_class_prob (req_det.cp),
      .req_class_id   (req_det.cls),
      .req_frame_last (req_det.last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kept       (rsp_got.kept),
      .rsp_pix_top    (rsp_got.top),
      .rsp_pix_left   (rsp_got.left),
      .rsp_pix_bottom (rsp_got.bottom),
      .rsp_pix_right  (rsp_got.right),
      .rsp_kept_score (rsp_got.score),
      .rsp_kept_class (rsp_got.cls),
      .rsp_frame_done (rsp_got.frame_done),
      .rsp_store_full (rsp_got.store_full),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   // Every response beat is checked at the edge that accepts it. All inputs
   // change through nonblocking assignments, so the values read here are the
   // ones that were stable before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_got);
   end

   // The watchdog counts cycles in which no channel moves a beat. The slowest
   // legal gap is one detection's pass through the ring plus the long
   // receiver hold-off, so the limit sits well above both.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 5000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Receiver: random stall bursts, one long hold-off on request so that the
   // block fills and pushes back on the request channel, otherwise ready.
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_ready <= 0;
            repeat (600) @(posedge clock);
            long_hold = 0;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ready <= 1;
         end
      end
   end

   // Offers one detection and returns at the edge that accepts it. Valid is
   // only lowered when a sender gap follows, so it never drops and rises
   // again within one step.
   task automatic send_detection(input detection_type d);
      if (idling_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid <= 1;
      req_det   <= d;
      do @(posedge clock); while (!req_ready);
      sb.log_detection(d);
      detections_sent++;
   endtask

   task automatic write_csr(input cbn_pkg::csr_index_type idx, input logic [15:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      sb.write_reg(idx, data);
   endtask

   // The sender stops and waits for every pending verdict to come back.
   task automatic drain();
      req_valid <= 0;
      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] conf, input logic [15:0] iou,
                            input logic [15:0] height, input logic [15:0] width);
      write_csr(cbn_pkg::CSR_CONF_THRESHOLD, conf);
      write_csr(cbn_pkg::CSR_IOU_THRESHOLD, iou);
      write_csr(cbn_pkg::CSR_IMAGE_HEIGHT, height);
      write_csr(cbn_pkg::CSR_IMAGE_WIDTH, width);
   endtask

   function automatic detection_type make_det(int cx, int cy, int bw, int bh, int obj,
                                              int cp, int cls, bit last);
      detection_type d;
      d.cx   = cx[15:0];
      d.cy   = cy[15:0];
      d.bw   = bw[14:0];
      d.bh   = bh[14:0];
      d.obj  = obj[15:0];
      d.cp   = cp[15:0];
      d.cls  = cls[7:0];
      d.last = last;
      return d;
   endfunction

   // A frame that keeps more boxes than the store holds. Each detection has
   // a class of its own, so none suppresses another, and the last ones come
   // back flagged as not stored.
   task automatic overflow_frame();
      for (int i = 0; i < cbn_pkg::MAX_KEPT_DEF + 3; i++)
         send_detection(make_det($urandom_range(0, 8191), $urandom_range(0, 8191),
                                 $urandom_range(1, 2000), $urandom_range(1, 2000),
                                 65535, 65535, i, i == cbn_pkg::MAX_KEPT_DEF + 2));
   endtask

   // A well-formed frame: boxes clustered around one spot with a handful of
   // classes, so suppression and near misses happen often.
   task automatic clustered_frame();
      int n, base_x, base_y, base_cls, spread;
      n        = $urandom_range(1, 12);
      base_x   = $urandom_range(0, 8191);
      base_y   = $urandom_range(0, 8191);
      base_cls = $urandom_range(0, 253);
      spread   = $urandom_range(0, 1) ? 64 : 1024;
      for (int i = 0; i < n; i++)
         send_detection(make_det(base_x + $urandom_range(0, spread) - spread / 2,
                                 base_y + $urandom_range(0, spread) - spread / 2,
                                 $urandom_range(0, 6000), $urandom_range(0, 6000),
                                 $urandom_range(20000, 65535), $urandom_range(20000, 65535),
                                 base_cls + $urandom_range(0, 2), i == n - 1));
   endtask

   task automatic noise_detection();
      logic [127:0]  raw;
      detection_type d;
      raw = {$urandom, $urandom, $urandom, $urandom};
      d   = raw[$bits(detection_type)-1:0];
      send_detection(d);
   endtask

   // Random traffic for one register setting until the running total of
   // detections reaches the given mark.
   task automatic random_phase(input int upto);
      int pick;
      while (detections_sent < upto) begin
         pick = $urandom_range(0, 99);
         if (pick < 70) clustered_frame();
         else if (pick < 97) noise_detection();
         else overflow_frame();
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed detections under the reset settings. A box identical to a
      // kept box of the same class is suppressed, the same box in another
      // class is kept, disjoint boxes have an empty
      // overlap, and two zero-area boxes have a zero union.
      send_detection(make_det(4096, 4096, 2048, 2048, 65535, 65535, 3, 0));
      send_detection(make_det(4096, 4096, 2048, 2048, 65535, 65535, 3, 0));
      send_detection(make_det(4096, 4096, 2048, 2048, 65535, 65535, 4, 0));
      send_detection(make_det(4300, 4200, 2048, 2048, 60000, 65535, 3, 0));
      send_detection(make_det(8192, 4096, 2048, 2048, 60000, 65535, 3, 0));
      send_detection(make_det(12288, 4096, 0, 0, 60000, 65535, 7, 0));
      send_detection(make_det(12288, 4096, 0, 0, 60000, 65535, 7, 0));
      send_detection(make_det(-32768, -32768, 32767, 32767, 65535, 65535, 9, 0));
      send_detection(make_det(32767, 32767, 32767, 32767, 65535, 65535, 10, 0));
      send_detection(make_det(32767, -32768, 0, 32767, 65535, 65535, 255, 0));
      send_detection(make_det(0, 0, 0, 0, 0, 65535, 0, 0));
      send_detection(make_det(100, 100, 50, 50, 65535, 0, 0, 0));
      send_detection(make_det(1000, 1000, 500, 500, 46341, 46341, 1, 0));
      send_detection(make_det(1000, 1000, 500, 500, 46340, 46340, 2, 1));
      overflow_frame();
      // After the frame end the store is empty again, so this box survives.
      send_detection(make_det(4096, 4096, 2048, 2048, 65535, 65535, 3, 1));
      drain();

      configure(16'd0, 16'd0, 16'd1, 16'd1);
      random_phase(230);
      drain();

      configure(16'd65535, 16'd65535, 16'd4096, 16'd4096);
      random_phase(370);
      drain();

      // The receiver holds off for a long stretch while detections keep
      // coming, which backs the block up onto its request channel.
      configure(16'd16384, 16'd29491, 16'd416, 16'd640);
      long_hold = 1;
      random_phase(520);
      drain();

      // A zero image height and the widest value the register takes.
      configure(16'd0, 16'd32768, 16'd0, 16'd8191);
      random_phase(660);
      drain();

      configure(16'd40000, 16'd10000, 16'd1080, 16'd1920);
      random_phase(800);
      drain();

      configure(16'd8000, 16'd50000, 16'd4096, 16'd1);
      random_phase(950);
      drain();

      // The last stretch runs at full rate with no gaps on either side.
      configure(16'd32768, 16'd29491, 16'd416, 16'd416);
      idling_on = 0;
      random_phase(1150);
      drain();
      repeat (100) @(posedge clock);

      if (sb.mismatches == 0 && sb.pending_verdicts.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
design/cbn_pkg.sv
design/cbn_cell.sv
design/cbn_iou.sv
design/class_aware_box_nms_unit.sv
tb/testbench.sv
